/* hdl/rect_block_copy_swap_engine_core_macros.svh */
// Assertion helpers for the checker file.
`ifndef RECT_BLOCK_COPY_SWAP_ENGINE_CORE_MACROS_SVH
`define RECT_BLOCK_COPY_SWAP_ENGINE_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define RBCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbcs assertion failed (same cycle)");

// Check cons in the cycle after ante.
`define RBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbcs assertion failed (next cycle)");

`endif

/* hdl/rbcs_pkg.sv */
package rbcs_pkg;

  localparam int CoordW  = 8;
  localparam int SizeW   = 9;
  localparam int PixelW  = 24;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [SizeW-1:0] IMAGE_WIDTH_RESET  = 9'd256;
  localparam logic [SizeW-1:0] IMAGE_HEIGHT_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_COPY  = 2'd2,
    CMD_SWAP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ_A,
    BK_READ_B,
    BK_WRITE_A,
    BK_WRITE_B,
    BK_FINISH
  } bk_state_e;

  // Classified command as it travels from the front part to the back part.
  typedef struct packed {
    cmd_e              cmd;
    logic              reject;
    logic              nop;
    logic [SizeW-1:0]  w;
    logic [SizeW-1:0]  h;
    logic [PixelW-1:0] pixel;
  } job_t;

endpackage

/* hdl/rbcs_fifo.sv */
module rbcs_fifo #(
  parameter int Width = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/rbcs_front.sv */
module rbcs_front import rbcs_pkg::*; #(
  parameter int WW = 10,
  parameter int HW = 10,
  parameter int AW = 16
) (
  input  logic [1:0]        command_i,
  input  logic [CoordW-1:0] dest_x_i,
  input  logic [CoordW-1:0] dest_y_i,
  input  logic [SizeW-1:0]  block_width_i,
  input  logic [SizeW-1:0]  block_height_i,
  input  logic [CoordW-1:0] src_x_i,
  input  logic [CoordW-1:0] src_y_i,
  input  logic [PixelW-1:0] write_pixel_i,
  input  logic [WW-1:0]     eff_w_i,
  input  logic [HW-1:0]     eff_h_i,
  output job_t              job_o,
  output logic [AW-1:0]     dest_addr_o,
  output logic [AW-1:0]     src_addr_o
);

  localparam int PW = CoordW + WW;

  cmd_e             cmd;
  logic             is_pixel;
  logic [SizeW-1:0] bw, bh;
  logic [WW-1:0]    dx_end, sx_end;
  logic [HW-1:0]    dy_end, sy_end;
  logic [PW-1:0]    dest_lin, src_lin;

  assign cmd      = cmd_e'(command_i);
  assign is_pixel = (cmd == CMD_WRITE) || (cmd == CMD_READ);

  // Pixel commands act as a 1x1 block at the destination.
  assign bw = is_pixel ? SizeW'(1) : block_width_i;
  assign bh = is_pixel ? SizeW'(1) : block_height_i;

  assign dx_end = WW'(dest_x_i) + WW'(bw);
  assign sx_end = WW'(src_x_i) + WW'(bw);
  assign dy_end = HW'(dest_y_i) + HW'(bh);
  assign sy_end = HW'(src_y_i) + HW'(bh);

  assign dest_lin = PW'(dest_y_i) * PW'(eff_w_i) + PW'(dest_x_i);
  assign src_lin  = PW'(src_y_i) * PW'(eff_w_i) + PW'(src_x_i);

  assign dest_addr_o = AW'(dest_lin);
  assign src_addr_o  = AW'(src_lin);

  always_comb begin
    job_o.cmd    = cmd;
    job_o.reject = (dx_end > eff_w_i) || (dy_end > eff_h_i) ||
                   (!is_pixel && ((sx_end > eff_w_i) || (sy_end > eff_h_i)));
    job_o.nop    = !is_pixel && ((block_width_i == '0) || (block_height_i == '0));
    job_o.w      = block_width_i;
    job_o.h      = block_height_i;
    job_o.pixel  = write_pixel_i;
  end

endmodule

/* hdl/rbcs_back.sv */
module rbcs_back import rbcs_pkg::*; #(
  parameter int WW    = 10,
  parameter int AW    = 16,
  parameter int Depth = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  job_t              job_i,
  input  logic [AW-1:0]     dest_addr_i,
  input  logic [AW-1:0]     src_addr_i,
  input  logic [WW-1:0]     eff_w_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_o,
  output logic [PixelW-1:0] read_pixel_o
);

  logic [PixelW-1:0] frame_mem [Depth];

  bk_state_e         state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic              reject_q, reject_d;
  logic [SizeW-1:0]  w_q, w_d, h_q, h_d;
  logic [SizeW-1:0]  col_q, col_d, row_q, row_d;
  logic [PixelW-1:0] pixel_q, pixel_d;
  logic [PixelW-1:0] keep_q, keep_d;
  logic [PixelW-1:0] rdata_q;
  logic [AW-1:0]     da_q, da_d, sa_q, sa_d;
  logic [AW-1:0]     da_row_q, da_row_d, sa_row_q, sa_row_d;
  logic              out_valid_q, out_valid_d;
  logic              status_q;
  logic [PixelW-1:0] read_pixel_q;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [PixelW-1:0] mem_wdata;
  logic              load_out;
  logic              col_last, row_last;
  logic [AW-1:0]     row_step;
  bk_state_e         pixel_start;

  assign col_last    = (col_q == w_q - SizeW'(1));
  assign row_last    = (row_q == h_q - SizeW'(1));
  assign row_step    = AW'(eff_w_i);
  assign pixel_start = (cmd_q == CMD_SWAP) ? BK_READ_A : BK_READ_B;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_pixel_o = read_pixel_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    reject_d    = reject_q;
    w_d         = w_q;
    h_d         = h_q;
    col_d       = col_q;
    row_d       = row_q;
    pixel_d     = pixel_q;
    keep_d      = keep_q;
    da_d        = da_q;
    sa_d        = sa_q;
    da_row_d    = da_row_q;
    sa_row_d    = sa_row_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = da_q;
    mem_wdata   = rdata_q;
    load_out    = 1'b0;
    job_ready_o = (state_q == BK_IDLE);

    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          cmd_d    = job_i.cmd;
          reject_d = job_i.reject;
          w_d      = job_i.w;
          h_d      = job_i.h;
          pixel_d  = job_i.pixel;
          da_d     = dest_addr_i;
          sa_d     = src_addr_i;
          da_row_d = dest_addr_i;
          sa_row_d = src_addr_i;
          col_d    = '0;
          row_d    = '0;
          priority if (job_i.reject || job_i.nop) begin
            state_d = BK_FINISH;
          end else begin
            unique case (job_i.cmd)
              CMD_WRITE: state_d = BK_WRITE_A;
              CMD_READ:  state_d = BK_READ_A;
              CMD_COPY:  state_d = BK_READ_B;
              CMD_SWAP:  state_d = BK_READ_A;
              default:   state_d = BK_FINISH;
            endcase
          end
        end
      end
      BK_READ_A: begin
        mem_re   = 1'b1;
        mem_addr = da_q;
        state_d  = (cmd_q == CMD_READ) ? BK_FINISH : BK_READ_B;
      end
      BK_READ_B: begin
        // Hold the destination pixel read in the previous cycle for the swap.
        mem_re   = 1'b1;
        mem_addr = sa_q;
        keep_d   = rdata_q;
        state_d  = BK_WRITE_A;
      end
      BK_WRITE_A, BK_WRITE_B: begin
        mem_we    = 1'b1;
        mem_addr  = (state_q == BK_WRITE_B) ? sa_q : da_q;
        mem_wdata = (state_q == BK_WRITE_B) ? keep_q :
                    (cmd_q == CMD_WRITE)    ? pixel_q : rdata_q;
        if (cmd_q == CMD_WRITE) begin
          state_d = BK_FINISH;
        end else if (state_q == BK_WRITE_A && cmd_q == CMD_SWAP) begin
          state_d = BK_WRITE_B;
        end else if (col_last && row_last) begin
          state_d = BK_FINISH;
        end else if (col_last) begin
          // Advance both rectangles to the start of the next row.
          col_d    = '0;
          row_d    = row_q + SizeW'(1);
          da_row_d = da_row_q + row_step;
          sa_row_d = sa_row_q + row_step;
          da_d     = da_row_q + row_step;
          sa_d     = sa_row_q + row_step;
          state_d  = pixel_start;
        end else begin
          col_d   = col_q + SizeW'(1);
          da_d    = da_q + AW'(1);
          sa_d    = sa_q + AW'(1);
          state_d = pixel_start;
        end
      end
      BK_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    reject_q <= reject_d;
    w_q      <= w_d;
    h_q      <= h_d;
    col_q    <= col_d;
    row_q    <= row_d;
    pixel_q  <= pixel_d;
    keep_q   <= keep_d;
    da_q     <= da_d;
    sa_q     <= sa_d;
    da_row_q <= da_row_d;
    sa_row_q <= sa_row_d;
    if (load_out) begin
      status_q     <= reject_q;
      read_pixel_q <= (cmd_q == CMD_READ && !reject_q) ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= frame_mem[mem_addr];
    end
  end

endmodule

/* hdl/rect_block_copy_swap_engine_core.sv */
// 2D block copy / swap engine over a single-port frame store of 24-bit RGB pixels.
// Input channel: command with coordinates, block size and write value; a transaction
// is taken when in_valid_i is high and in_stall_o is low. Output channel: one status
// and read value per command, taken when out_valid_o is high and out_stall_i is low.
// Config channel: cfg_index_i 0 sets image width, 1 sets image height; always ready.
// Write config only while no command is in flight.
// Steps per command, set by the one frame store port (one access per cycle):
//   rejected or empty: finish; write pixel: write, finish; read pixel: read, finish;
//   copy: read source, write destination per pixel; swap: read both, write both.
// A two-entry queue sits between the classifier and the executor, so up to two
// further commands are taken while one runs, and a finished result waits in the
// output register without holding up the queue.
// Reset clears the control state and restores width and height to 256; the frame
// store keeps whatever it held and needs no clearing pass.
// While out_stall_i is high the result holds, the executor parks in its finish step,
// and in_stall_o rises once the queue fills.
module rect_block_copy_swap_engine_core import rbcs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [CoordW-1:0]  dest_x_i,
  input  logic [CoordW-1:0]  dest_y_i,
  input  logic [SizeW-1:0]   block_width_i,
  input  logic [SizeW-1:0]   block_height_i,
  input  logic [CoordW-1:0]  src_x_i,
  input  logic [CoordW-1:0]  src_y_i,
  input  logic [PixelW-1:0]  write_pixel_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [PixelW-1:0]  read_pixel_o,
  // config channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i
);

  // Keep comparison widths wide enough for an 8-bit coordinate plus a 9-bit size.
  localparam int WClog = $clog2(MAX_WIDTH + 1);
  localparam int HClog = $clog2(MAX_HEIGHT + 1);
  localparam int WW    = (WClog > 10) ? WClog : 10;
  localparam int HW    = (HClog > 10) ? HClog : 10;
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AClog = $clog2(Depth);
  localparam int AW    = (AClog < 1) ? 1 : AClog;
  localparam int JobW  = $bits(job_t) + 2 * AW;

  logic [SizeW-1:0] image_width_q, image_width_d;
  logic [SizeW-1:0] image_height_q, image_height_d;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;

  job_t             front_job, back_job;
  logic [AW-1:0]    front_da, front_sa, back_da, back_sa;
  logic             q_push_ready, q_pop_valid, q_pop_ready;
  logic [JobW-1:0]  q_pop_data;

  // Config registers: take every write, drop unknown indexes.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    image_width_d  = image_width_q;
    image_height_d = image_height_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  image_width_d  = cfg_data_i;
        CFG_IMAGE_HEIGHT: image_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RESET;
      image_height_q <= IMAGE_HEIGHT_RESET;
    end else begin
      image_width_q  <= image_width_d;
      image_height_q <= image_height_d;
    end
  end

  // Saturate the picture size to what the frame store holds.
  assign eff_w = (WW'(image_width_q) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) :
                 WW'(image_width_q);
  assign eff_h = (HW'(image_height_q) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) :
                 HW'(image_height_q);

  assign in_stall_o = !q_push_ready;

  rbcs_front #(
    .WW (WW),
    .HW (HW),
    .AW (AW)
  ) u_front (
    .command_i      (command_i),
    .dest_x_i       (dest_x_i),
    .dest_y_i       (dest_y_i),
    .block_width_i  (block_width_i),
    .block_height_i (block_height_i),
    .src_x_i        (src_x_i),
    .src_y_i        (src_y_i),
    .write_pixel_i  (write_pixel_i),
    .eff_w_i        (eff_w),
    .eff_h_i        (eff_h),
    .job_o          (front_job),
    .dest_addr_o    (front_da),
    .src_addr_o     (front_sa)
  );

  rbcs_fifo #(
    .Width (JobW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (q_push_ready),
    .push_data_i  ({front_job, front_da, front_sa}),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  assign {back_job, back_da, back_sa} = q_pop_data;

  rbcs_back #(
    .WW    (WW),
    .AW    (AW),
    .Depth (Depth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_pop_valid),
    .job_ready_o  (q_pop_ready),
    .job_i        (back_job),
    .dest_addr_i  (back_da),
    .src_addr_i   (back_sa),
    .eff_w_i      (eff_w),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .read_pixel_o (read_pixel_o)
  );

endmodule

/* hdl/rbcs_checker.sv */
`include "rect_block_copy_swap_engine_core_macros.svh"

module rbcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        status_o,
  input logic [23:0] read_pixel_o
);

  logic       in_take, out_take;
  logic [3:0] pending_q;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // Count commands taken but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 4'd0;
    end else begin
      pending_q <= pending_q + 4'(in_take) - 4'(out_take);
    end
  end

  `RBCS_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `RBCS_ASSERT_NOW(a_reject_reads_zero, clk_i, rst_ni, out_valid_o && status_o, read_pixel_o == 24'd0)
  `RBCS_ASSERT_NOW(a_result_has_command, clk_i, rst_ni, out_valid_o, pending_q != 4'd0)
  `RBCS_ASSERT_NOW(a_stall_means_backlog, clk_i, rst_ni, in_stall_o, pending_q >= 4'd2)

endmodule

bind rect_block_copy_swap_engine_core rbcs_checker u_checker (.*);
